FILE: rtl/sbfr_pkg.sv
// ----------------------------------------------------------------------------
// sbfr_pkg
// Shared constants and types for the serial-bus frame receiver.
// ----------------------------------------------------------------------------
package sbfr_pkg;

    localparam int BYTE_W       = 8;
    localparam int FRAME_LEN    = 24;
    localparam int DATA_BYTES   = 22;
    localparam int NUM_CHANNELS = 16;
    localparam int CHAN_W       = 11;
    localparam int INDEX_W      = 4;
    localparam int POS_W        = 5;
    localparam int DATA_W       = DATA_BYTES * BYTE_W;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h0F;
    localparam logic [BYTE_W-1:0] END_BYTE    = 8'h00;

    typedef struct packed {
        logic              error;
        logic [DATA_W-1:0] data;
    } frame_rec_t;

endpackage

FILE: rtl/sbfr_front.sv
// ----------------------------------------------------------------------------
// sbfr_front
// Byte classifier: finds the header, gathers frame bytes, checks end bytes.
// ----------------------------------------------------------------------------
module sbfr_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [sbfr_pkg::BYTE_W-1:0] rx_byte,
    output logic                       rec_push,
    output sbfr_pkg::frame_rec_t       rec
);

    logic                              open_reg;
    logic                              open_next;
    logic [sbfr_pkg::POS_W-1:0]        pos_reg;
    logic [sbfr_pkg::POS_W-1:0]        pos_next;
    logic [sbfr_pkg::BYTE_W-1:0]       prev_reg;
    logic [sbfr_pkg::BYTE_W-1:0]       prev_next;
    logic [sbfr_pkg::DATA_W-1:0]       data_reg;
    logic [sbfr_pkg::DATA_W-1:0]       data_next;
    logic                              closing;

    assign closing = accept && open_reg
                     && (pos_reg == sbfr_pkg::POS_W'(sbfr_pkg::FRAME_LEN - 1));

    always_comb
    begin
        open_next = open_reg;
        pos_next  = pos_reg;
        prev_next = prev_reg;
        data_next = data_reg;
        if (accept)
        begin
            if (!open_reg)
            begin
                if (rx_byte == sbfr_pkg::HEADER_BYTE && prev_reg == sbfr_pkg::END_BYTE)
                begin
                    open_next = 1'b1;
                    pos_next  = '0;
                end
                prev_next = rx_byte;
            end
            else if (closing)
            begin
                // hold previous byte at the flags byte
                open_next = 1'b0;
                pos_next  = '0;
            end
            else
            begin
                if (pos_reg < sbfr_pkg::POS_W'(sbfr_pkg::DATA_BYTES))
                begin
                    data_next = {rx_byte, data_reg[sbfr_pkg::DATA_W-1:sbfr_pkg::BYTE_W]};
                end
                pos_next  = pos_reg + 1'b1;
                prev_next = rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            pos_reg  <= '0;
            prev_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
            pos_reg  <= pos_next;
            prev_reg <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign rec_push   = closing;
    assign rec.error  = !(rx_byte == sbfr_pkg::END_BYTE && prev_reg == sbfr_pkg::END_BYTE);
    assign rec.data   = data_reg;

endmodule

FILE: rtl/sbfr_queue.sv
// ----------------------------------------------------------------------------
// sbfr_queue
// Short queue of completed frame records between front and back.
// ----------------------------------------------------------------------------
module sbfr_queue
#(
    parameter int DEPTH = sbfr_pkg::QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sbfr_pkg::frame_rec_t wr_rec,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output sbfr_pkg::frame_rec_t rd_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sbfr_pkg::frame_rec_t mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_rec  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("frame record pushed into full queue");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("frame record popped from empty queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");
`endif

endmodule

FILE: rtl/sbfr_back.sv
// ----------------------------------------------------------------------------
// sbfr_back
// Channel unpacker: emits sixteen 11-bit channels or one error word.
// ----------------------------------------------------------------------------
module sbfr_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  sbfr_pkg::frame_rec_t          q_rec,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [sbfr_pkg::INDEX_W-1:0]  channel_index,
    output logic [sbfr_pkg::CHAN_W-1:0]   channel_value,
    output logic                          frame_error,
    output logic                          last
);

    logic                           busy_reg;
    logic                           busy_next;
    logic                           err_reg;
    logic                           err_next;
    logic [sbfr_pkg::DATA_W-1:0]    cur_reg;
    logic [sbfr_pkg::DATA_W-1:0]    cur_next;
    logic [sbfr_pkg::INDEX_W-1:0]   ch_reg;
    logic [sbfr_pkg::INDEX_W-1:0]   ch_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [sbfr_pkg::INDEX_W-1:0]   idx_reg;
    logic [sbfr_pkg::INDEX_W-1:0]   idx_next;
    logic [sbfr_pkg::CHAN_W-1:0]    val_reg;
    logic [sbfr_pkg::CHAN_W-1:0]    val_next;
    logic                           oerr_reg;
    logic                           oerr_next;
    logic                           olast_reg;
    logic                           olast_next;
    logic                           advance;
    logic                           ch_final;

    assign advance  = busy_reg && (!out_valid_reg || pop);
    assign ch_final = (ch_reg == sbfr_pkg::INDEX_W'(sbfr_pkg::NUM_CHANNELS - 1));
    assign q_pop    = !busy_reg && !q_empty;

    always_comb
    begin
        busy_next      = busy_reg;
        err_next       = err_reg;
        cur_next       = cur_reg;
        ch_next        = ch_reg;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        oerr_next      = oerr_reg;
        olast_next     = olast_reg;
        if (q_pop)
        begin
            busy_next = 1'b1;
            err_next  = q_rec.error;
            cur_next  = q_rec.data;
            ch_next   = '0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (err_reg)
            begin
                idx_next   = '0;
                val_next   = '0;
                oerr_next  = 1'b1;
                olast_next = 1'b1;
                busy_next  = 1'b0;
            end
            else
            begin
                idx_next   = ch_reg;
                val_next   = cur_reg[sbfr_pkg::CHAN_W-1:0];
                oerr_next  = 1'b0;
                olast_next = ch_final;
                cur_next   = cur_reg >> sbfr_pkg::CHAN_W;
                ch_next    = ch_reg + 1'b1;
                busy_next  = !ch_final;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        cur_reg   <= cur_next;
        ch_reg    <= ch_next;
        idx_reg   <= idx_next;
        val_reg   <= val_next;
        oerr_reg  <= oerr_next;
        olast_reg <= olast_next;
    end

    assign empty         = !out_valid_reg;
    assign channel_index = idx_reg;
    assign channel_value = val_reg;
    assign frame_error   = oerr_reg;
    assign last          = olast_reg;

`ifndef SYNTHESIS
    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && oerr_reg) |-> (olast_reg && idx_reg == '0 && val_reg == '0))
        else $error("error word is not a lone final word");
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !busy_reg)
        else $error("frame record taken while unpacking");
`endif

endmodule

FILE: rtl/sbus_frame_receiver.sv
// ----------------------------------------------------------------------------
// sbus_frame_receiver
// Serial-bus frame receiver: header search, 24-byte frame capture, end-byte
// check and unpacking into sixteen 11-bit channels.
//
//   channel   direction  handshake           payload
//   input     in         push / full         rx_byte[7:0]
//   result    out        empty / pop         channel_index[3:0],
//                                            channel_value[10:0],
//                                            frame_error, last
//
// One byte is taken per cycle while the frame queue has room.
// A closed frame's record goes through the queue and is then loaded into the
// unpacker before its first word shows; the rest follow one per cycle while
// pop is high. The next record is loaded only after a frame's last word.
// pop low holds the current word and the unpacker.
// full rises only when QUEUE_DEPTH frame records wait behind the unpacker.
// rst_n clears control state at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sbus_frame_receiver
#(
    parameter int QUEUE_DEPTH = sbfr_pkg::QUEUE_DEPTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [sbfr_pkg::BYTE_W-1:0]   rx_byte,
    output logic                          empty,
    input  logic                          pop,
    output logic [sbfr_pkg::INDEX_W-1:0]  channel_index,
    output logic [sbfr_pkg::CHAN_W-1:0]   channel_value,
    output logic                          frame_error,
    output logic                          last
);

    logic                 accept;
    logic                 rec_push;
    sbfr_pkg::frame_rec_t wr_rec;
    sbfr_pkg::frame_rec_t rd_rec;
    logic                 q_empty;
    logic                 q_pop;

    assign accept = push && !full;

    sbfr_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .rec_push (rec_push),
        .rec      (wr_rec)
    );

    sbfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (rec_push),
        .wr_rec (wr_rec),
        .full   (full),
        .pop    (q_pop),
        .empty  (q_empty),
        .rd_rec (rd_rec)
    );

    sbfr_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_rec         (rd_rec),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .frame_error   (frame_error),
        .last          (last)
    );

endmodule

FILE: bench/sbus_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbus_frame_receiver_tb
// Feeds serial bytes into the frame receiver: a short table of frames first,
// then random frames with noise and broken end bytes between them, under
// several patterns of sender gaps and receiver stalls. Every word taken from
// the result queue is compared with the channel words decoded by a frame
// model kept alongside the block, or with the fixed words a table row names.
// ----------------------------------------------------------------------------
module sbus_frame_receiver_tb;

    localparam int                          ITEM_TARGET = 410;
    localparam logic [sbfr_pkg::CHAN_W-1:0] VALUE_MAX   = 11'h7FF;

    typedef enum logic [1:0] {
        EXPECT_MODEL,
        EXPECT_ALL_MAX,
        EXPECT_ERROR
    } row_check_t;

    typedef struct packed {
        logic [sbfr_pkg::BYTE_W-1:0] value;
        logic [7:0]                  count;
        row_check_t                  check;
    } stim_row_t;

    typedef struct packed {
        logic [sbfr_pkg::INDEX_W-1:0] index;
        logic [sbfr_pkg::CHAN_W-1:0]  value;
        logic                         error;
        logic                         last;
    } channel_word_t;

    logic                          clk;
    logic                          rst_n;
    logic                          push;
    logic                          full;
    logic [sbfr_pkg::BYTE_W-1:0]   rx_byte;
    logic                          empty;
    logic                          pop;
    logic [sbfr_pkg::INDEX_W-1:0]  channel_index;
    logic [sbfr_pkg::CHAN_W-1:0]   channel_value;
    logic                          frame_error;
    logic                          last;

    logic [sbfr_pkg::BYTE_W-1:0]   captured_bytes [sbfr_pkg::FRAME_LEN];
    int                            capture_pos;
    bit                            capture_open;
    logic [sbfr_pkg::BYTE_W-1:0]   prev_rx_byte;
    channel_word_t                 decoded_words [sbfr_pkg::NUM_CHANNELS];
    channel_word_t                 pending_words [$];
    channel_word_t                 want_word;
    int                            sent_items;
    int                            failures;
    int                            send_idle_pct;
    int                            pop_stall_pct;

    stim_row_t directed_rows [11] = '{
        '{8'h0F, 8'd1,  EXPECT_MODEL},
        '{8'hFF, 8'd22, EXPECT_MODEL},
        '{8'h00, 8'd1,  EXPECT_MODEL},
        '{8'h00, 8'd1,  EXPECT_ALL_MAX},
        '{8'h0F, 8'd1,  EXPECT_MODEL},
        '{8'h00, 8'd1,  EXPECT_MODEL},
        '{8'h0F, 8'd1,  EXPECT_MODEL},
        '{8'h00, 8'd19, EXPECT_MODEL},
        '{8'h80, 8'd1,  EXPECT_MODEL},
        '{8'h00, 8'd1,  EXPECT_MODEL},
        '{8'hFF, 8'd1,  EXPECT_ERROR}
    };

    int send_idle_by_phase [4] = '{0, 47, 0, 28};
    int pop_stall_by_phase [4] = '{0, 0, 47, 28};

    sbus_frame_receiver DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .rx_byte       (rx_byte),
        .empty         (empty),
        .pop           (pop),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .frame_error   (frame_error),
        .last          (last)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        failures++;
    endtask

    // Frame model: header search while idle, capture, end-byte check, unpack.
    task automatic decode_rx_byte(input logic [sbfr_pkg::BYTE_W-1:0] b, output int n);
        logic [sbfr_pkg::DATA_W-1:0] bits;
        n = 0;
        if (!capture_open)
        begin
            if (b == sbfr_pkg::HEADER_BYTE && prev_rx_byte == sbfr_pkg::END_BYTE)
            begin
                capture_open = 1'b1;
                capture_pos  = 0;
            end
            prev_rx_byte = b;
        end
        else
        begin
            captured_bytes[capture_pos] = b;
            capture_pos++;
            if (capture_pos < sbfr_pkg::FRAME_LEN)
            begin
                prev_rx_byte = b;
            end
            else
            begin
                // hold the flags byte as the previous byte
                capture_open = 1'b0;
                capture_pos  = 0;
                if (b == sbfr_pkg::END_BYTE && prev_rx_byte == sbfr_pkg::END_BYTE)
                begin
                    for (int i = 0; i < sbfr_pkg::DATA_BYTES; i++)
                        bits[i*sbfr_pkg::BYTE_W +: sbfr_pkg::BYTE_W] = captured_bytes[i];
                    for (int k = 0; k < sbfr_pkg::NUM_CHANNELS; k++)
                    begin
                        decoded_words[k].index = sbfr_pkg::INDEX_W'(k);
                        decoded_words[k].value = bits[k*sbfr_pkg::CHAN_W +: sbfr_pkg::CHAN_W];
                        decoded_words[k].error = 1'b0;
                        decoded_words[k].last  = (k == sbfr_pkg::NUM_CHANNELS - 1);
                    end
                    n = sbfr_pkg::NUM_CHANNELS;
                end
                else
                begin
                    decoded_words[0] = '{index: '0, value: '0, error: 1'b1, last: 1'b1};
                    n = 1;
                end
            end
        end
    endtask

    task automatic send_byte(input logic [sbfr_pkg::BYTE_W-1:0] b, input row_check_t check);
        int n;
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push    <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sent_items++;
        decode_rx_byte(b, n);
        case (check)
            EXPECT_ALL_MAX:
            begin
                for (int k = 0; k < sbfr_pkg::NUM_CHANNELS; k++)
                begin
                    decoded_words[k].index = sbfr_pkg::INDEX_W'(k);
                    decoded_words[k].value = VALUE_MAX;
                    decoded_words[k].error = 1'b0;
                    decoded_words[k].last  = (k == sbfr_pkg::NUM_CHANNELS - 1);
                end
                n = sbfr_pkg::NUM_CHANNELS;
            end
            EXPECT_ERROR:
            begin
                decoded_words[0] = '{index: '0, value: '0, error: 1'b1, last: 1'b1};
                n = 1;
            end
            default: ;
        endcase
        for (int k = 0; k < n; k++)
            pending_words.push_back(decoded_words[k]);
    endtask

    task automatic send_random_frame();
        logic [sbfr_pkg::BYTE_W-1:0] data_byte;
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom_range(255)), EXPECT_MODEL);
        if (prev_rx_byte != sbfr_pkg::END_BYTE || $urandom_range(1))
            send_byte(sbfr_pkg::END_BYTE, EXPECT_MODEL);
        send_byte(sbfr_pkg::HEADER_BYTE, EXPECT_MODEL);
        for (int i = 0; i < sbfr_pkg::DATA_BYTES; i++)
        begin
            case ($urandom_range(7))
                0:       data_byte = sbfr_pkg::END_BYTE;
                1:       data_byte = sbfr_pkg::HEADER_BYTE;
                2:       data_byte = 8'hFF;
                default: data_byte = 8'($urandom_range(255));
            endcase
            send_byte(data_byte, EXPECT_MODEL);
        end
        for (int i = 0; i < 2; i++)
        begin
            data_byte = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                 : sbfr_pkg::END_BYTE;
            send_byte(data_byte, EXPECT_MODEL);
        end
    endtask

    task automatic drain_words();
        @(negedge clk);
        push <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    always @(negedge clk)
        pop <= ($urandom_range(99) >= pop_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word: index %0d value %0d error %0b last %0b",
                                          channel_index, channel_value, frame_error, last));
            end
            else
            begin
                want_word = pending_words.pop_front();
                if (channel_index !== want_word.index)
                    report_mismatch($sformatf("channel_index %0d, expected %0d",
                                              channel_index, want_word.index));
                if (channel_value !== want_word.value)
                    report_mismatch($sformatf("channel_value %0d, expected %0d (channel %0d)",
                                              channel_value, want_word.value, want_word.index));
                if (frame_error !== want_word.error)
                    report_mismatch($sformatf("frame_error %0b, expected %0b",
                                              frame_error, want_word.error));
                if (last !== want_word.last)
                    report_mismatch($sformatf("last %0b, expected %0b (channel %0d)",
                                              last, want_word.last, want_word.index));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        push          = 1'b0;
        rx_byte       = '0;
        pop           = 1'b0;
        failures      = 0;
        sent_items    = 0;
        capture_open  = 1'b0;
        capture_pos   = 0;
        prev_rx_byte  = sbfr_pkg::END_BYTE;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        for (int i = 0; i < sbfr_pkg::FRAME_LEN; i++)
            captured_bytes[i] = '0;

        repeat (7) @(posedge clk);
        if (empty !== 1'b1 || full !== 1'b0)
            report_mismatch($sformatf("after reset empty %b full %b", empty, full));
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            for (int j = 0; j < directed_rows[r].count; j++)
                send_byte(directed_rows[r].value,
                          (j == directed_rows[r].count - 1) ? directed_rows[r].check
                                                            : EXPECT_MODEL);
        end
        drain_words();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = send_idle_by_phase[phase];
            pop_stall_pct = pop_stall_by_phase[phase];
            while (sent_items < (phase + 1) * ITEM_TARGET / 4)
                send_random_frame();
            // hold the sender until the result queue has run dry
            drain_words();
        end

        repeat (50) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/sbfr_pkg.sv
rtl/sbfr_front.sv
rtl/sbfr_queue.sv
rtl/sbfr_back.sv
rtl/sbus_frame_receiver.sv
bench/sbus_frame_receiver_tb.sv
